[rtl/usb_transfer_packetizer_unit_defines.svh]
// ----------------------------------------------------------------------------
// USB transfer packetizer assertion macros
// Shared macros for the concurrent assertions of the packetizer checker.
// ----------------------------------------------------------------------------
`ifndef USB_TRANSFER_PACKETIZER_UNIT_DEFINES_SVH
`define USB_TRANSFER_PACKETIZER_UNIT_DEFINES_SVH

// Assertion that is switched off while reset is held.
`define USBTP_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Assertion that is checked at every edge, reset included.
`define USBTP_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);

`endif

[rtl/usbtp_pkg.sv]
// ----------------------------------------------------------------------------
// USB transfer packetizer package
// Constants, codes and shared types of the packetizer front and back parts.
// ----------------------------------------------------------------------------
package usbtp_pkg;

    // Largest number of data packets that one request may need.
    localparam int MAX_DATA_PACKETS = 62;

    // Per-endpoint toggle store: one bit for each device address and endpoint.
    localparam int TOGGLE_DEPTH = 2048;
    localparam int TOGGLE_AW    = 11;

    // Command queue between front and back; the depth is a power of two.
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

    // Transfer modes on the input channel.
    localparam logic [1:0] MODE_CONTROL = 2'd0;
    localparam logic [1:0] MODE_BULK    = 2'd1;
    localparam logic [1:0] MODE_ISO     = 2'd2;

    // Token kinds on the result channel.
    localparam logic [1:0] PID_SETUP = 2'd0;
    localparam logic [1:0] PID_IN    = 2'd1;
    localparam logic [1:0] PID_OUT   = 2'd2;

    // Length codes of the setup packet and of a zero-length packet.
    localparam logic [10:0] SETUP_LENGTH = 11'd7;
    localparam logic [10:0] NULL_LENGTH  = 11'h7FF;

    // Class of a request as decided by the front part.
    typedef enum logic [1:0] {
        KIND_CONTROL,
        KIND_BULK,
        KIND_ISO,
        KIND_REJECT
    } kind_t;

    // Classified request as it travels through the command queue.
    typedef struct packed {
        kind_t       kind;
        logic        dir_out;
        logic [6:0]  dev_addr;
        logic [3:0]  ep_num;
        logic [9:0]  max_packet;
        logic [15:0] xfer_len;
        logic [31:0] buf_addr;
        logic [31:0] setup_addr;
    } cmd_t;

    // One packet descriptor on the result channel.
    typedef struct packed {
        logic [1:0]  pid;
        logic [6:0]  target_addr;
        logic [3:0]  target_ep;
        logic        toggle;
        logic [10:0] length_code;
        logic [31:0] pkt_addr;
        logic        iso;
        logic        ioc;
        logic        req_error;
        logic        last;
    } desc_t;

    // Sequencer states of the back part.
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOAD,
        ST_SETUP,
        ST_DATA,
        ST_STATUS,
        ST_ERROR
    } state_t;

endpackage

[rtl/usb_transfer_packetizer_unit.sv]
// ----------------------------------------------------------------------------
// USB transfer packetizer
// Expands transfer requests into USB packet descriptors in schedule order.
//
//   Channel   Ports      Word
//   request   s_axis     one transfer request, mode in s_tuser
//   packet    m_axis     one packet descriptor, token kind in m_tuser
//
// A rejected request gives one descriptor, a non-control request its data
// packets and a control request a setup packet, its data packets and a status
// packet. The sequencer emits one descriptor a cycle unless the packet side
// stalls; a non-control request first waits in the load state on the
// registered toggle memory read. After reset the toggle memory is cleared,
// during which no request is taken. A stall on the packet side holds the
// descriptor in the output register; up to two requests wait in the queue.
// ----------------------------------------------------------------------------
module usb_transfer_packetizer_unit (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // s_tuser: mode
    input  logic [1:0]   s_tuser,
    // s_tdata: direction_out, device_address, endpoint_number, max_packet,
    //          transfer_length, buffer_address, setup_address, zero fill
    input  logic [103:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // m_tuser: packet_id
    output logic [1:0]   m_tuser,
    // m_tdata: target_address, target_endpoint, data_toggle, length_code,
    //          packet_address, isochronous, interrupt_on_complete,
    //          request_error, zero fill
    output logic [63:0]  m_tdata,
    output logic         m_tlast
);

    logic             queue_full;
    logic             queue_valid;
    logic             queue_pop;
    logic             push;
    logic             init_done;
    usbtp_pkg::cmd_t  push_cmd;
    usbtp_pkg::cmd_t  head_cmd;
    usbtp_pkg::desc_t desc;

    // Request classification.
    usbtp_front u_front (
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tuser    (s_tuser),
        .s_tdata    (s_tdata),
        .queue_full (queue_full),
        .init_done  (init_done),
        .push       (push),
        .push_cmd   (push_cmd)
    );

    // Queue between the two parts.
    usbtp_cmd_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (queue_pop),
        .full     (queue_full),
        .valid    (queue_valid),
        .head     (head_cmd)
    );

    // Descriptor sequencer.
    usbtp_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd_valid (queue_valid),
        .cmd       (head_cmd),
        .cmd_pop   (queue_pop),
        .init_done (init_done),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_desc  (desc)
    );

    // Descriptor packing.
    assign m_tuser = desc.pid;
    assign m_tlast = desc.last;
    assign m_tdata = {6'd0, desc.req_error, desc.ioc, desc.iso, desc.pkt_addr,
                      desc.length_code, desc.toggle, desc.target_ep, desc.target_addr};

endmodule

[rtl/usbtp_ram.sv]
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with a registered read.
// ----------------------------------------------------------------------------
module usbtp_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write and registered read.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[rtl/usbtp_front.sv]
// ----------------------------------------------------------------------------
// USB transfer packetizer front part
// Unpacks request words and classifies them before they enter the queue.
// ----------------------------------------------------------------------------
module usbtp_front (
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [1:0]        s_tuser,
    input  logic [103:0]      s_tdata,
    input  logic              queue_full,
    input  logic              init_done,
    output logic              push,
    output usbtp_pkg::cmd_t   push_cmd
);

    logic [16:0]       len_limit;
    logic              too_many;
    logic              empty_len;
    usbtp_pkg::kind_t  kind;

    // Words are taken whenever the queue has room and the toggle store is clear.
    assign s_tready = !queue_full && init_done;
    assign push     = s_tvalid && s_tready;

    // Request fields.
    assign push_cmd.kind       = kind;
    assign push_cmd.dir_out    = s_tdata[0];
    assign push_cmd.dev_addr   = s_tdata[7:1];
    assign push_cmd.ep_num     = s_tdata[11:8];
    assign push_cmd.max_packet = s_tdata[21:12];
    assign push_cmd.xfer_len   = s_tdata[37:22];
    assign push_cmd.buf_addr   = s_tdata[69:38];
    assign push_cmd.setup_addr = s_tdata[101:70];

    // More packets than allowed exactly when the length exceeds the limit
    // times the packet size; a zero packet size rejects any nonempty stage.
    assign len_limit = 17'(push_cmd.max_packet) * 17'(usbtp_pkg::MAX_DATA_PACKETS);
    assign too_many  = {1'b0, push_cmd.xfer_len} > len_limit;
    assign empty_len = push_cmd.xfer_len == 16'd0;

    // Classification by mode.
    always_comb begin
        case (s_tuser)
            usbtp_pkg::MODE_CONTROL: begin
                kind = too_many ? usbtp_pkg::KIND_REJECT : usbtp_pkg::KIND_CONTROL;
            end
            usbtp_pkg::MODE_BULK: begin
                kind = (too_many || empty_len) ? usbtp_pkg::KIND_REJECT
                                               : usbtp_pkg::KIND_BULK;
            end
            usbtp_pkg::MODE_ISO: begin
                kind = (too_many || empty_len) ? usbtp_pkg::KIND_REJECT
                                               : usbtp_pkg::KIND_ISO;
            end
            default: begin
                kind = usbtp_pkg::KIND_REJECT;
            end
        endcase
    end

endmodule

[rtl/usbtp_cmd_queue.sv]
// ----------------------------------------------------------------------------
// USB transfer packetizer command queue
// Short queue of classified requests between the front and back parts.
// ----------------------------------------------------------------------------
module usbtp_cmd_queue (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push,
    input  usbtp_pkg::cmd_t push_cmd,
    input  logic            pop,
    output logic            full,
    output logic            valid,
    output usbtp_pkg::cmd_t head
);

    usbtp_pkg::cmd_t                  entry_reg [usbtp_pkg::QUEUE_DEPTH];
    logic [usbtp_pkg::QUEUE_AW-1:0]   wr_ptr_reg;
    logic [usbtp_pkg::QUEUE_AW-1:0]   wr_ptr_next;
    logic [usbtp_pkg::QUEUE_AW-1:0]   rd_ptr_reg;
    logic [usbtp_pkg::QUEUE_AW-1:0]   rd_ptr_next;
    logic [usbtp_pkg::QUEUE_CW-1:0]   count_reg;
    logic [usbtp_pkg::QUEUE_CW-1:0]   count_next;

    // Pointer and fill count update.
    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage.
    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    assign full  = count_reg == usbtp_pkg::QUEUE_CW'(usbtp_pkg::QUEUE_DEPTH);
    assign valid = count_reg != '0;
    assign head  = entry_reg[rd_ptr_reg];

endmodule

[rtl/usbtp_back.sv]
// ----------------------------------------------------------------------------
// USB transfer packetizer back part
// Sequencer that turns queued requests into packet descriptors and keeps the
// per-endpoint data toggle.
// ----------------------------------------------------------------------------
module usbtp_back (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             cmd_valid,
    input  usbtp_pkg::cmd_t  cmd,
    output logic             cmd_pop,
    output logic             init_done,
    output logic             out_valid,
    input  logic             out_ready,
    output usbtp_pkg::desc_t out_desc
);

    usbtp_pkg::state_t              state_reg, state_next;
    logic [usbtp_pkg::TOGGLE_AW-1:0] clear_cnt_reg, clear_cnt_next;
    logic                           init_done_reg, init_done_next;
    usbtp_pkg::kind_t               kind_reg, kind_next;
    logic                           dir_out_reg, dir_out_next;
    logic [6:0]                     dev_addr_reg, dev_addr_next;
    logic [3:0]                     ep_num_reg, ep_num_next;
    logic [9:0]                     mp_reg, mp_next;
    logic [15:0]                    remain_reg, remain_next;
    logic [31:0]                    pkt_addr_reg, pkt_addr_next;
    logic [31:0]                    setup_addr_reg, setup_addr_next;
    logic                           tog_reg, tog_next;
    logic                           out_valid_reg, out_valid_next;
    usbtp_pkg::desc_t               desc_reg, desc_next;

    logic                           ram_we;
    logic [usbtp_pkg::TOGGLE_AW-1:0] ram_waddr;
    logic [0:0]                     ram_wdata;
    logic                           ram_re;
    logic [usbtp_pkg::TOGGLE_AW-1:0] ram_raddr;
    logic [0:0]                     ram_rdata;

    logic                           out_free;
    logic                           last_chunk;
    logic [9:0]                     chunk;
    logic                           is_ctrl;
    logic [usbtp_pkg::TOGGLE_AW-1:0] tog_idx;

    // Toggle store, one bit per device endpoint.
    usbtp_ram #(
        .WIDTH (1),
        .DEPTH (usbtp_pkg::TOGGLE_DEPTH)
    ) u_toggle_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Size of the next data packet and whether it ends the data stage.
    assign last_chunk = {6'd0, mp_reg} >= remain_reg;
    assign chunk      = last_chunk ? remain_reg[9:0] : mp_reg;
    assign is_ctrl    = kind_reg == usbtp_pkg::KIND_CONTROL;
    assign tog_idx    = {dev_addr_reg, ep_num_reg};
    assign out_free   = !out_valid_reg || out_ready;

    // Next state and outputs of the sequencer.
    always_comb begin
        state_next      = state_reg;
        clear_cnt_next  = clear_cnt_reg;
        init_done_next  = init_done_reg;
        kind_next       = kind_reg;
        dir_out_next    = dir_out_reg;
        dev_addr_next   = dev_addr_reg;
        ep_num_next     = ep_num_reg;
        mp_next         = mp_reg;
        remain_next     = remain_reg;
        pkt_addr_next   = pkt_addr_reg;
        setup_addr_next = setup_addr_reg;
        tog_next        = tog_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        desc_next       = desc_reg;
        cmd_pop         = 1'b0;
        ram_we          = 1'b0;
        ram_waddr       = tog_idx;
        ram_wdata       = 1'b0;
        ram_re          = 1'b0;
        ram_raddr       = {cmd.dev_addr, cmd.ep_num};

        case (state_reg)
            // Zero the toggle store after reset, one entry a cycle.
            usbtp_pkg::ST_CLEAR: begin
                ram_we         = 1'b1;
                ram_waddr      = clear_cnt_reg;
                clear_cnt_next = clear_cnt_reg + 1'b1;
                if (clear_cnt_reg == '1) begin
                    init_done_next = 1'b1;
                    state_next     = usbtp_pkg::ST_IDLE;
                end
            end

            // Take the next request and start the toggle read.
            usbtp_pkg::ST_IDLE: begin
                if (cmd_valid) begin
                    cmd_pop         = 1'b1;
                    ram_re          = 1'b1;
                    kind_next       = cmd.kind;
                    dir_out_next    = cmd.dir_out;
                    dev_addr_next   = cmd.dev_addr;
                    ep_num_next     = cmd.ep_num;
                    mp_next         = cmd.max_packet;
                    remain_next     = cmd.xfer_len;
                    pkt_addr_next   = cmd.buf_addr;
                    setup_addr_next = cmd.setup_addr;
                    case (cmd.kind)
                        usbtp_pkg::KIND_CONTROL: state_next = usbtp_pkg::ST_SETUP;
                        usbtp_pkg::KIND_BULK:    state_next = usbtp_pkg::ST_LOAD;
                        usbtp_pkg::KIND_ISO:     state_next = usbtp_pkg::ST_LOAD;
                        default:                 state_next = usbtp_pkg::ST_ERROR;
                    endcase
                end
            end

            // The stored toggle of the endpoint is now available.
            usbtp_pkg::ST_LOAD: begin
                tog_next   = ram_rdata[0];
                state_next = usbtp_pkg::ST_DATA;
            end

            // Setup packet of a control transfer.
            usbtp_pkg::ST_SETUP: begin
                if (out_free) begin
                    out_valid_next        = 1'b1;
                    desc_next             = '0;
                    desc_next.pid         = usbtp_pkg::PID_SETUP;
                    desc_next.target_addr = dev_addr_reg;
                    desc_next.target_ep   = ep_num_reg;
                    desc_next.length_code = usbtp_pkg::SETUP_LENGTH;
                    desc_next.pkt_addr    = setup_addr_reg;
                    tog_next              = 1'b1;
                    state_next = (remain_reg == 16'd0) ? usbtp_pkg::ST_STATUS
                                                       : usbtp_pkg::ST_DATA;
                end
            end

            // One data packet a word; the last one of a non-control request writes the toggle back.
            usbtp_pkg::ST_DATA: begin
                if (out_free) begin
                    out_valid_next        = 1'b1;
                    desc_next             = '0;
                    desc_next.pid         = dir_out_reg ? usbtp_pkg::PID_OUT
                                                        : usbtp_pkg::PID_IN;
                    desc_next.target_addr = dev_addr_reg;
                    desc_next.target_ep   = ep_num_reg;
                    desc_next.toggle      = tog_reg;
                    desc_next.length_code = {1'b0, chunk - 10'd1};
                    desc_next.pkt_addr    = pkt_addr_reg;
                    desc_next.iso         = kind_reg == usbtp_pkg::KIND_ISO;
                    desc_next.ioc         = last_chunk && !is_ctrl;
                    desc_next.last        = last_chunk && !is_ctrl;
                    tog_next              = !tog_reg;
                    remain_next           = remain_reg - {6'd0, chunk};
                    pkt_addr_next         = pkt_addr_reg + {22'd0, mp_reg};
                    if (last_chunk) begin
                        if (is_ctrl) begin
                            state_next = usbtp_pkg::ST_STATUS;
                        end else begin
                            ram_we     = 1'b1;
                            ram_wdata  = !tog_reg;
                            state_next = usbtp_pkg::ST_IDLE;
                        end
                    end
                end
            end

            // Zero-length status packet in the opposite direction.
            usbtp_pkg::ST_STATUS: begin
                if (out_free) begin
                    out_valid_next        = 1'b1;
                    desc_next             = '0;
                    desc_next.pid         = dir_out_reg ? usbtp_pkg::PID_IN
                                                        : usbtp_pkg::PID_OUT;
                    desc_next.target_addr = dev_addr_reg;
                    desc_next.target_ep   = ep_num_reg;
                    desc_next.toggle      = 1'b1;
                    desc_next.length_code = usbtp_pkg::NULL_LENGTH;
                    desc_next.last        = 1'b1;
                    state_next            = usbtp_pkg::ST_IDLE;
                end
            end

            // Single result of a rejected request.
            usbtp_pkg::ST_ERROR: begin
                if (out_free) begin
                    out_valid_next      = 1'b1;
                    desc_next           = '0;
                    desc_next.req_error = 1'b1;
                    desc_next.last      = 1'b1;
                    state_next          = usbtp_pkg::ST_IDLE;
                end
            end

            default: begin
                state_next = usbtp_pkg::ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= usbtp_pkg::ST_CLEAR;
            clear_cnt_reg <= '0;
            init_done_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            clear_cnt_reg <= clear_cnt_next;
            init_done_reg <= init_done_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Request and descriptor registers.
    always_ff @(posedge aclk) begin
        kind_reg       <= kind_next;
        dir_out_reg    <= dir_out_next;
        dev_addr_reg   <= dev_addr_next;
        ep_num_reg     <= ep_num_next;
        mp_reg         <= mp_next;
        remain_reg     <= remain_next;
        pkt_addr_reg   <= pkt_addr_next;
        setup_addr_reg <= setup_addr_next;
        tog_reg        <= tog_next;
        desc_reg       <= desc_next;
    end

    assign init_done = init_done_reg;
    assign out_valid = out_valid_reg;
    assign out_desc  = desc_reg;

endmodule

[rtl/usbtp_checker.sv]
// ----------------------------------------------------------------------------
// USB transfer packetizer checker
// Port-level assertions on the packetizer, attached by a bind statement.
// ----------------------------------------------------------------------------
`include "usb_transfer_packetizer_unit_defines.svh"

module usbtp_checker (
    input logic         aclk,
    input logic         aresetn,
    input logic         s_tready,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [1:0]   m_tuser,
    input logic [63:0]  m_tdata,
    input logic         m_tlast
);

    // A stalled descriptor word holds.
    `USBTP_ASSERT(a_stall_hold,
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
            && $stable(m_tlast),
        "descriptor changed while stalled")

    // A rejected request gives one result that ends it, all else zero.
    `USBTP_ASSERT(a_error_word,
        m_tvalid && m_tdata[57] |-> m_tlast && m_tdata[56:0] == 57'd0
            && m_tuser == usbtp_pkg::PID_SETUP,
        "malformed error result")

    // The setup packet is eight bytes of DATA0 and never the last result.
    `USBTP_ASSERT(a_setup_word,
        m_tvalid && m_tuser == usbtp_pkg::PID_SETUP && !m_tdata[57]
            |-> m_tdata[22:12] == usbtp_pkg::SETUP_LENGTH && !m_tdata[11] && !m_tlast,
        "malformed setup packet")

    // Right after reset nothing is taken and nothing is offered, as the toggle store is clearing.
    `USBTP_ASSERT_ALWAYS(a_reset_quiet,
        !aresetn |=> !s_tready && !m_tvalid,
        "activity right after reset")

endmodule

bind usb_transfer_packetizer_unit usbtp_checker u_checker (.*);

[tb/usb_transfer_packetizer_unit_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// USB transfer packetizer testbench
// Sends transfer requests on the request stream and checks every packet
// descriptor that comes back against a behavioural predictor of the block.
// A short table of directed requests covers the edge cases; a long run of
// mostly well-formed random requests follows, with random gaps on the
// request side and stalls on the packet side.
// ----------------------------------------------------------------------------
module usb_transfer_packetizer_unit_tb;

    // Mode code that the block must always refuse.
    localparam logic [1:0] MODE_RESERVED = 2'd3;

    localparam int N_DIRECTED     = 22;
    localparam int RANDOM_WORDS   = 450;
    localparam int WATCHDOG_LIMIT = 10000;
    localparam int SETTLE_CYCLES  = 16;

    // Result of a refused request: only the error and last flags are set.
    localparam usbtp_pkg::desc_t REJECT_DESC = '{req_error: 1'b1, last: 1'b1, default: '0};

    // One transfer request as the testbench sees it.
    typedef struct packed {
        logic [1:0]  mode;
        logic        dir_out;
        logic [6:0]  dev_addr;
        logic [3:0]  ep;
        logic [9:0]  max_packet;
        logic [15:0] xfer_len;
        logic [31:0] buf_addr;
        logic [31:0] setup_addr;
    } transfer_req_t;

    // Directed row: a request and, for refusals, the descriptor typed in.
    typedef struct packed {
        transfer_req_t    req;
        logic             has_typed;
        usbtp_pkg::desc_t typed;
    } directed_row_t;

    logic         aclk     = 1'b0;
    logic         aresetn  = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [1:0]   s_tuser  = '0;
    logic [103:0] s_tdata  = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [1:0]   m_tuser;
    logic [63:0]  m_tdata;
    logic         m_tlast;

    // Predictor state: one toggle bit per device endpoint.
    bit               ep_toggle [usbtp_pkg::TOGGLE_DEPTH];
    usbtp_pkg::desc_t expected_descs [$];

    int burst_left   = 0;
    int quiet_cycles = 0;
    int stall_style  = 0;
    int style_left   = 0;
    int mismatches   = 0;
    int n_requests   = 0;
    int n_rejected   = 0;
    int n_control    = 0;
    int n_bulk       = 0;
    int n_iso        = 0;
    int n_checked    = 0;

    always #5 aclk = ~aclk;

    usb_transfer_packetizer_unit uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tuser  (m_tuser),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    function automatic transfer_req_t make_req(logic [1:0] mode, logic dir_out,
                                               logic [6:0] dev_addr, logic [3:0] ep,
                                               logic [9:0] max_packet,
                                               logic [15:0] xfer_len,
                                               logic [31:0] buf_addr,
                                               logic [31:0] setup_addr);
        transfer_req_t r;
        r = '{mode, dir_out, dev_addr, ep, max_packet, xfer_len, buf_addr, setup_addr};
        return r;
    endfunction

    // Expands one accepted request into the descriptors it must produce.
    task automatic expand_request(input transfer_req_t r);
        usbtp_pkg::desc_t d;
        int unsigned      npk;
        int unsigned      done;
        int unsigned      chunk;
        int unsigned      mp;
        int unsigned      len;
        logic [10:0]      slot;
        logic             tog;
        mp  = r.max_packet;
        len = r.xfer_len;
        if (len == 0) begin
            npk = 0;
        end else if (mp == 0) begin
            npk = usbtp_pkg::MAX_DATA_PACKETS + 1;
        end else begin
            npk = (len + mp - 1) / mp;
        end
        if (r.mode == MODE_RESERVED || npk > usbtp_pkg::MAX_DATA_PACKETS ||
            (r.mode != usbtp_pkg::MODE_CONTROL && len == 0)) begin
            expected_descs.push_back(REJECT_DESC);
            n_rejected++;
            return;
        end

        d             = '0;
        d.target_addr = r.dev_addr;
        d.target_ep   = r.ep;
        slot          = {r.dev_addr, r.ep};
        if (r.mode == usbtp_pkg::MODE_CONTROL) begin
            // The setup stage always goes first with DATA0.
            d.pid         = usbtp_pkg::PID_SETUP;
            d.length_code = usbtp_pkg::SETUP_LENGTH;
            d.pkt_addr    = r.setup_addr;
            expected_descs.push_back(d);
            tog = 1'b1;
            n_control++;
        end else begin
            tog   = ep_toggle[slot];
            d.iso = (r.mode == usbtp_pkg::MODE_ISO);
            if (r.mode == usbtp_pkg::MODE_ISO) n_iso++;
            else n_bulk++;
        end

        // Data packets of at most max_packet bytes, toggle alternating.
        done = 0;
        while (done < len) begin
            chunk = len - done;
            if (chunk > mp) chunk = mp;
            d.pid         = r.dir_out ? usbtp_pkg::PID_OUT : usbtp_pkg::PID_IN;
            d.toggle      = tog;
            d.length_code = 11'(chunk - 1);
            d.pkt_addr    = r.buf_addr + 32'(done);
            d.ioc         = (r.mode != usbtp_pkg::MODE_CONTROL) && (done + chunk == len);
            d.last        = d.ioc;
            expected_descs.push_back(d);
            tog  = ~tog;
            done = done + chunk;
        end

        if (r.mode == usbtp_pkg::MODE_CONTROL) begin
            // Zero-length status stage in the opposite direction, DATA1.
            d.pid         = r.dir_out ? usbtp_pkg::PID_IN : usbtp_pkg::PID_OUT;
            d.toggle      = 1'b1;
            d.length_code = usbtp_pkg::NULL_LENGTH;
            d.pkt_addr    = '0;
            d.ioc         = 1'b0;
            d.last        = 1'b1;
            expected_descs.push_back(d);
        end else begin
            ep_toggle[slot] = tog;
        end
    endtask

    // Mostly well-formed requests on a few busy endpoints, with some noise.
    function automatic transfer_req_t random_request();
        transfer_req_t r;
        int npk;
        int lo;
        int hi;
        r.dir_out    = 1'($urandom_range(0, 1));
        r.buf_addr   = $urandom;
        r.setup_addr = $urandom;
        if ($urandom_range(0, 3) == 0) begin
            r.dev_addr = 7'($urandom_range(0, 127));
            r.ep       = 4'($urandom_range(0, 15));
        end else begin
            r.dev_addr = 7'($urandom_range(120, 123));
            r.ep       = 4'($urandom_range(14, 15));
        end
        if ($urandom_range(0, 99) < 8) begin
            r.mode       = 2'($urandom_range(0, 3));
            r.max_packet = 10'($urandom_range(0, 1023));
            r.xfer_len   = 16'($urandom_range(0, 65535));
        end else begin
            r.mode       = 2'($urandom_range(0, 2));
            r.max_packet = ($urandom_range(0, 3) == 0) ? 10'($urandom_range(1, 1023))
                                                       : 10'($urandom_range(1, 64));
            npk = ($urandom_range(0, 9) == 0)
                ? $urandom_range(1, usbtp_pkg::MAX_DATA_PACKETS)
                : $urandom_range(1, 6);
            if (r.mode == usbtp_pkg::MODE_CONTROL && $urandom_range(0, 4) == 0) begin
                r.xfer_len = '0;
            end else begin
                hi = npk * int'(r.max_packet);
                if (hi > 65535) hi = 65535;
                lo = (npk - 1) * int'(r.max_packet) + 1;
                if (lo > hi) lo = hi;
                r.xfer_len = 16'($urandom_range(lo, hi));
            end
        end
        return r;
    endfunction

    // Offers one request word in the current burst, or after a random gap.
    task automatic send_request(input transfer_req_t r, input logic has_typed,
                                input usbtp_pkg::desc_t typed);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                @(negedge aclk);
                s_tvalid <= 1'b0;
                repeat (gap - 1) @(negedge aclk);
            end
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 60)
                                                     : $urandom_range(1, 10);
        end
        burst_left--;
        @(negedge aclk);
        s_tuser  <= r.mode;
        s_tdata  <= {2'b00, r.setup_addr, r.buf_addr, r.xfer_len, r.max_packet,
                     r.ep, r.dev_addr, r.dir_out};
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        n_requests++;
        if (has_typed) begin
            expected_descs.push_back(typed);
            n_rejected++;
        end else begin
            expand_request(r);
        end
    endtask

    // Holds the request side off until every outstanding descriptor is in.
    task automatic drain_results();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (expected_descs.size() != 0) @(posedge aclk);
        burst_left = 0;
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            $display("%0t ns: %s mismatch, expected %0h, got %0h", $time, name, want, got);
            mismatches++;
        end
    endtask

    // The packet side stalls in styles that are picked at random and change from one stretch to the next.
    always @(negedge aclk) begin
        if (style_left == 0) begin
            stall_style <= $urandom_range(0, 3);
            style_left  <= $urandom_range(50, 300);
        end else begin
            style_left  <= style_left - 1;
        end
        case (stall_style)
            0: begin
                m_tready <= 1'b1;
            end
            1: begin
                m_tready <= ($urandom_range(0, 9) < 7);
            end
            2: begin
                m_tready <= (style_left % 3 == 0);
            end
            default: begin
                m_tready <= ($urandom_range(0, 15) == 0);
            end
        endcase
    end

    // Descriptor checking and the watchdog on accepted words.
    always @(posedge aclk) begin : result_check
        usbtp_pkg::desc_t want;
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles = 0;
            else quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t ns: no word accepted for %0d cycles", $time, WATCHDOG_LIMIT);
                $display("FAILED: results differ");
                $finish;
            end else if (m_tvalid && m_tready) begin
                if (expected_descs.size() == 0) begin
                    $display({"%0t ns: unexpected descriptor, expected none, ",
                              "got pid %0d data %h last %b"},
                             $time, m_tuser, m_tdata, m_tlast);
                    mismatches++;
                end else begin
                    want = expected_descs.pop_front();
                    n_checked++;
                    check_field("packet_id", want.pid, m_tuser);
                    check_field("target_address", want.target_addr, m_tdata[6:0]);
                    check_field("target_endpoint", want.target_ep, m_tdata[10:7]);
                    check_field("data_toggle", want.toggle, m_tdata[11]);
                    check_field("length_code", want.length_code, m_tdata[22:12]);
                    check_field("packet_address", want.pkt_addr, m_tdata[54:23]);
                    check_field("isochronous", want.iso, m_tdata[55]);
                    check_field("interrupt_on_complete", want.ioc, m_tdata[56]);
                    check_field("request_error", want.req_error, m_tdata[57]);
                    check_field("last_packet", want.last, m_tlast);
                end
            end
        end
    end

    initial begin : stimulus
        directed_row_t rows [N_DIRECTED];
        int i;
        // First bulk request after reset starts from DATA0.
        rows[0]  = '{make_req(usbtp_pkg::MODE_BULK, 1'b0, 7'd0, 4'd0, 10'd8, 16'd20,
                              32'h0000_1000, 32'h0), 1'b0, '0};
        // Control with an empty data stage and zero max_packet is still served.
        rows[1]  = '{make_req(usbtp_pkg::MODE_CONTROL, 1'b0, 7'd1, 4'd0, 10'd0, 16'd0,
                              32'h0, 32'h0000_2000), 1'b0, '0};
        rows[2]  = '{make_req(usbtp_pkg::MODE_CONTROL, 1'b1, 7'd127, 4'd15, 10'd8, 16'd8,
                              32'hFFFF_FFFF, 32'hFFFF_FFFF), 1'b0, '0};
        // Largest control transfer: setup, 62 data packets and status.
        rows[3]  = '{make_req(usbtp_pkg::MODE_CONTROL, 1'b0, 7'd2, 4'd1, 10'd1, 16'd62,
                              32'h0010_0000, 32'h0020_0000), 1'b0, '0};
        // One data packet too many, control included.
        rows[4]  = '{make_req(usbtp_pkg::MODE_CONTROL, 1'b0, 7'd2, 4'd1, 10'd1, 16'd63,
                              32'h0010_0000, 32'h0020_0000), 1'b1, REJECT_DESC};
        // Zero max_packet with data to move.
        rows[5]  = '{make_req(usbtp_pkg::MODE_CONTROL, 1'b1, 7'd3, 4'd2, 10'd0, 16'd1,
                              32'h1234_5678, 32'h8765_4321), 1'b1, REJECT_DESC};
        // Empty non-control transfers.
        rows[6]  = '{make_req(usbtp_pkg::MODE_BULK, 1'b1, 7'd4, 4'd3, 10'd64, 16'd0,
                              32'hA5A5_A5A5, 32'h5A5A_5A5A), 1'b1, REJECT_DESC};
        rows[7]  = '{make_req(usbtp_pkg::MODE_ISO, 1'b0, 7'd5, 4'd4, 10'd64, 16'd0,
                              32'hA5A5_A5A5, 32'h5A5A_5A5A), 1'b1, REJECT_DESC};
        rows[8]  = '{make_req(MODE_RESERVED, 1'b1, 7'd6, 4'd5, 10'd64, 16'd100,
                              32'h0000_4000, 32'h0000_5000), 1'b1, REJECT_DESC};
        // Widest endpoint, largest packets, exactly the packet limit.
        rows[9]  = '{make_req(usbtp_pkg::MODE_BULK, 1'b1, 7'd127, 4'd15, 10'd1023,
                              16'd63426, 32'h8000_0000, 32'h0), 1'b0, '0};
        rows[10] = '{make_req(usbtp_pkg::MODE_BULK, 1'b0, 7'd127, 4'd15, 10'd1023, 16'd1,
                              32'h8000_0000, 32'h0), 1'b0, '0};
        rows[11] = '{make_req(usbtp_pkg::MODE_BULK, 1'b0, 7'd7, 4'd6, 10'd0, 16'd5,
                              32'h0, 32'h0), 1'b1, REJECT_DESC};
        // Packet address at the very top of the address space.
        rows[12] = '{make_req(usbtp_pkg::MODE_ISO, 1'b1, 7'd0, 4'd0, 10'd1, 16'd1,
                              32'hFFFF_FFFF, 32'h0), 1'b0, '0};
        rows[13] = '{make_req(usbtp_pkg::MODE_ISO, 1'b0, 7'd0, 4'd0, 10'd1023, 16'd65535,
                              32'hFFFF_FFFF, 32'hFFFF_FFFF), 1'b1, REJECT_DESC};
        rows[14] = '{make_req(usbtp_pkg::MODE_CONTROL, 1'b1, 7'd127, 4'd15, 10'd1023,
                              16'd65535, 32'hFFFF_FFFF, 32'hFFFF_FFFF), 1'b1, REJECT_DESC};
        rows[15] = '{make_req(usbtp_pkg::MODE_CONTROL, 1'b0, 7'd64, 4'd8, 10'd1023,
                              16'd63426, 32'h0000_0001, 32'hFFFF_FFF8), 1'b0, '0};
        rows[16] = '{make_req(usbtp_pkg::MODE_BULK, 1'b0, 7'd3, 4'd9, 10'd16, 16'd40,
                              32'hFFFF_FFF0, 32'h0), 1'b0, '0};
        rows[17] = '{make_req(usbtp_pkg::MODE_BULK, 1'b0, 7'd3, 4'd9, 10'd1023, 16'd1023,
                              32'h0000_0400, 32'h0), 1'b0, '0};
        rows[18] = '{make_req(usbtp_pkg::MODE_ISO, 1'b1, 7'd5, 4'd15, 10'd1000, 16'd3000,
                              32'h0003_0000, 32'h0), 1'b0, '0};
        // Bulk and isochronous traffic share the toggle of an endpoint.
        rows[19] = '{make_req(usbtp_pkg::MODE_BULK, 1'b0, 7'd0, 4'd0, 10'd16, 16'd32,
                              32'h0000_0800, 32'h0), 1'b0, '0};
        rows[20] = '{make_req(usbtp_pkg::MODE_ISO, 1'b1, 7'd9, 4'd7, 10'd0, 16'd0,
                              32'h0, 32'h0), 1'b1, REJECT_DESC};
        rows[21] = '{make_req(usbtp_pkg::MODE_CONTROL, 1'b1, 7'd85, 4'd10, 10'd1023, 16'd0,
                              32'h0, 32'h5555_5555), 1'b0, '0};

        repeat (12) @(negedge aclk);
        aresetn <= 1'b1;

        for (i = 0; i < N_DIRECTED; i++) begin
            send_request(rows[i].req, rows[i].has_typed, rows[i].typed);
        end
        drain_results();

        for (i = 0; i < RANDOM_WORDS; i++) begin
            if (i == RANDOM_WORDS / 2) drain_results();
            send_request(random_request(), 1'b0, '0);
        end
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge aclk);

        $display("Run covered %0d requests: %0d control, %0d bulk/interrupt, %0d iso, %0d refused.",
                 n_requests, n_control, n_bulk, n_iso, n_rejected);
        $display("%0d packet descriptors compared, %0d field mismatches.",
                 n_checked, mismatches);
        if (mismatches == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule

[files.f]
+incdir+rtl
rtl/usbtp_pkg.sv
rtl/usbtp_ram.sv
rtl/usbtp_front.sv
rtl/usbtp_cmd_queue.sv
rtl/usbtp_back.sv
rtl/usb_transfer_packetizer_unit.sv
rtl/usbtp_checker.sv
tb/usb_transfer_packetizer_unit_tb.sv
